>>> rtl/tar_pkg.sv
package tar_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int HOUR_W  = 5;
    localparam int BAND_W  = 2;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // tariff bands
    localparam logic [BAND_W-1:0] BAND_PEAK     = 2'd1;
    localparam logic [BAND_W-1:0] BAND_SHOULDER = 2'd2;
    localparam logic [BAND_W-1:0] BAND_OFF      = 2'd3;

    localparam logic [WDAY_W-1:0] WD_SUNDAY   = 3'd0;
    localparam logic [WDAY_W-1:0] WD_SATURDAY = 3'd6;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // reciprocal multipliers: y/100 = (y*5243)>>19, y/19 = (y*3450)>>16,
    // t/30 = (t*547)>>14, u/7 = (u*147)>>10, x/3 = (x*43)>>7 over their ranges
    localparam int Q100_MUL = 5243;
    localparam int Q19_MUL  = 3450;
    localparam int Q30_MUL  = 547;
    localparam int Q7_MUL   = 147;
    localparam int Q3_MUL   = 43;

    // timestamp fields that ride alongside the computus
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
    } ctx_t;

    // Easter Monday: march or april, and day of month
    typedef struct packed {
        logic             april;
        logic [DAY_W-1:0] day;
    } easter_t;

    function automatic logic fixed_holiday(input logic [MONTH_W-1:0] mon,
                                           input logic [DAY_W-1:0]   dd);
        fixed_holiday = (mon == MON_JAN && (dd == 5'd1 || dd == 5'd6)) ||
                        (mon == MON_APR && dd == 5'd25) ||
                        (mon == MON_MAY && dd == 5'd1)  ||
                        (mon == MON_JUN && dd == 5'd2)  ||
                        (mon == MON_AUG && dd == 5'd15) ||
                        (mon == MON_NOV && dd == 5'd1)  ||
                        (mon == MON_DEC && (dd == 5'd8 || dd == 5'd25 || dd == 5'd26));
    endfunction

endpackage

>>> rtl/tariff_time_band_classifier.sv
// Time-of-use tariff band classifier.
// Input stream s_*: one beat per local timestamp (year, month, day, weekday,
// hour). Output stream m_*: one beat per input beat, in order, carrying the
// tariff band (1 peak, 2 shoulder, 3 off-peak) and the holiday flag.
// Holidays are the ten fixed dates plus Easter Monday, found per beat with
// the Gregorian computus spread over five register stages, followed by the
// output register that holds the band and flag.
// Throughput: one beat per cycle while m_tready is high; every stage holds one beat and advances
// when it is empty or the stage after it moves.
// Stall: while m_tready is low the pipeline fills up; s_tready drops only
// once all six stages hold a beat. Nothing is dropped or repeated.
// Reset: rst_n clears all stage valid bits; no beat is pending afterward
// and s_tready is high in the first cycle after reset.
module tariff_time_band_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // year[11:0], month[15:12], day_of_month[20:16], weekday[23:21], hour[28:24]
    input  logic [tar_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // band[1:0], holiday[2]
    output logic [tar_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import tar_pkg::*;

    ctx_t              in_ctx;
    ctx_t              mid_ctx;
    easter_t           mid_easter;
    logic              mid_valid;
    logic              mid_ready;
    logic [BAND_W-1:0] band;
    logic              holiday;

    assign in_ctx.month   = s_tdata[15:12];
    assign in_ctx.day     = s_tdata[20:16];
    assign in_ctx.weekday = s_tdata[23:21];
    assign in_ctx.hour    = s_tdata[28:24];

    tar_easter u_easter (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .year       (s_tdata[YEAR_W-1:0]),
        .in_ctx     (in_ctx),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .out_ctx    (mid_ctx),
        .out_easter (mid_easter)
    );

    tar_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_ctx    (mid_ctx),
        .in_easter (mid_easter),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .band      (band),
        .holiday   (holiday)
    );

    assign m_tdata = {{(OUT_TDATA_W - BAND_W - 1){1'b0}}, holiday, band};

endmodule

>>> rtl/tar_easter.sv
module tar_easter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [tar_pkg::YEAR_W-1:0] year,
    input  tar_pkg::ctx_t             in_ctx,
    output logic                      out_valid,
    input  logic                      out_ready,
    output tar_pkg::ctx_t             out_ctx,
    output tar_pkg::easter_t          out_easter
);
    import tar_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] vin;
    logic [STAGES:0]   rdy;
    ctx_t              ctx_reg [STAGES];

    // stage 1
    logic [24:0] p100;
    logic [23:0] p19;
    logic [YEAR_W-1:0] y1_reg;
    logic [5:0]  q100_reg;
    logic [7:0]  q19_reg;

    // stage 2
    logic [11:0] c_full;
    logic [11:0] a_full;
    logic [6:0]  c;
    logic        f;
    logic [5:0]  g_arg;
    logic [11:0] g_prod;
    logic [6:0]  ub_next;
    logic [4:0]  a2_reg;
    logic [5:0]  b2_reg;
    logic [3:0]  d2_reg;
    logic [3:0]  g2_reg;
    logic [6:0]  ub2_reg;

    // stage 3
    logic [8:0]  t;
    logic [17:0] p30;
    logic [8:0]  h_full;
    logic [4:0]  a3_reg;
    logic [4:0]  h3_reg;
    logic [6:0]  ub3_reg;

    // stage 4
    logic [6:0]  u;
    logic [13:0] p7;
    logic [6:0]  l_full;
    logic [4:0]  a4_reg;
    logic [4:0]  h4_reg;
    logic [2:0]  l4_reg;

    // stage 5
    logic [8:0]  msum;
    logic        m;
    logic [7:0]  s;
    logic        april_s;
    logic [7:0]  sdm;
    easter_t     easter_next;
    easter_t     easter_reg;

    always_comb
    begin
        rdy[STAGES] = out_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign vin = {v_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= vin[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ctx_reg[0] <= in_ctx;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (rdy[i])
            begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    // stage 1: quotients by 100 and 19
    assign p100 = 25'(year) * 25'(Q100_MUL);
    assign p19  = 24'(year) * 24'(Q19_MUL);

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            y1_reg   <= year;
            q100_reg <= p100[24:19];
            q19_reg  <= p19[23:16];
        end
    end

    // stage 2: remainders, century terms
    assign c_full  = y1_reg - 12'(q100_reg) * 12'd100;
    assign a_full  = y1_reg - 12'(q19_reg) * 12'd19;
    assign c       = c_full[6:0];
    assign f       = (q100_reg >= 6'd17);
    assign g_arg   = q100_reg - 6'(f) + 6'd1;
    assign g_prod  = 12'(g_arg) * 12'(Q3_MUL);
    // 32 + 2e + 2i - k
    assign ub_next = 7'd32 + {4'd0, q100_reg[1:0], 1'b0} + {1'b0, c[6:2], 1'b0}
                   - 7'(c[1:0]);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            a2_reg  <= a_full[4:0];
            b2_reg  <= q100_reg;
            d2_reg  <= q100_reg[5:2];
            g2_reg  <= g_prod[10:7];
            ub2_reg <= ub_next;
        end
    end

    // stage 3: epact term h
    assign t      = 9'(a2_reg) * 9'd19 + 9'(b2_reg) - 9'(d2_reg) - 9'(g2_reg) + 9'd15;
    assign p30    = 18'(t) * 18'(Q30_MUL);
    assign h_full = t - 9'(p30[17:14]) * 9'd30;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            a3_reg  <= a2_reg;
            h3_reg  <= h_full[4:0];
            ub3_reg <= ub2_reg;
        end
    end

    // stage 4: weekday offset l
    assign u      = ub3_reg - 7'(h3_reg);
    assign p7     = 14'(u) * 14'(Q7_MUL);
    assign l_full = u - 7'(p7[13:10]) * 7'd7;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            a4_reg <= a3_reg;
            h4_reg <= h3_reg;
            l4_reg <= l_full[2:0];
        end
    end

    // stage 5: Easter Sunday, then one day on
    assign msum    = 9'(a4_reg) + 9'(h4_reg) * 9'd11 + 9'(l4_reg) * 9'd22;
    assign m       = (msum >= 9'd451);
    assign s       = 8'(h4_reg) + 8'(l4_reg) + 8'd114 - (m ? 8'd7 : 8'd0);
    assign april_s = (s >= 8'd124);
    assign sdm     = s - (april_s ? 8'd124 : 8'd93);

    always_comb
    begin
        if (!april_s && sdm == 8'd30)
        begin
            // Sunday on March 31
            easter_next.april = 1'b1;
            easter_next.day   = 5'd1;
        end
        else
        begin
            easter_next.april = april_s;
            easter_next.day   = sdm[4:0] + 5'd2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            easter_reg <= easter_next;
        end
    end

    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[STAGES-1];
    assign out_ctx    = ctx_reg[STAGES-1];
    assign out_easter = easter_reg;

endmodule

>>> rtl/tar_classify.sv
module tar_classify (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tar_pkg::ctx_t              in_ctx,
    input  tar_pkg::easter_t           in_easter,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tar_pkg::BAND_W-1:0] band,
    output logic                       holiday
);
    import tar_pkg::*;

    logic              valid_reg;
    logic              hol_next;
    logic              hol_reg;
    logic [BAND_W-1:0] band_next;
    logic [BAND_W-1:0] band_reg;
    logic [MONTH_W-1:0] easter_month;

    assign in_ready     = !valid_reg || out_ready;
    assign easter_month = in_easter.april ? MON_APR : MON_MAR;
    assign hol_next     = fixed_holiday(in_ctx.month, in_ctx.day) ||
                          (in_ctx.month == easter_month && in_ctx.day == in_easter.day);

    always_comb
    begin
        priority if (in_ctx.weekday == WD_SUNDAY || hol_next)
            band_next = BAND_OFF;
        else if (in_ctx.weekday == WD_SATURDAY)
            band_next = (in_ctx.hour >= 5'd7 && in_ctx.hour < 5'd23) ? BAND_SHOULDER : BAND_OFF;
        else if (in_ctx.hour >= 5'd8 && in_ctx.hour < 5'd19)
            band_next = BAND_PEAK;
        else if (in_ctx.hour == 5'd7 || (in_ctx.hour >= 5'd19 && in_ctx.hour < 5'd23))
            band_next = BAND_SHOULDER;
        else
            band_next = BAND_OFF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            band_reg <= band_next;
            hol_reg  <= hol_next;
        end
    end

    assign out_valid = valid_reg;
    assign band      = band_reg;
    assign holiday   = hol_reg;

endmodule

>>> rtl/tar_checker.sv
module tar_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tar_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tar_pkg::*;

    // a stalled beat stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed under stall");

    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[BAND_W-1:0] != 2'd0)
        else $error("band out of range");

    // holidays are always off-peak
    a_holiday_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[BAND_W] |-> m_tdata[BAND_W-1:0] == BAND_OFF)
        else $error("holiday beat not off-peak");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:BAND_W+1] == '0)
        else $error("m_tdata padding not zero");

endmodule

bind tariff_time_band_classifier tar_checker u_tar_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
